// ===== hdl/fpd_pkg.sv =====
// Shared types and constants of the fuzzy PD controller.
// No dependencies; every other file depends on this package.
package fpd_pkg;

    localparam int DATA_W  = 16;
    localparam int FRAC_W  = 8;
    localparam int DVD_W   = 28;
    localparam int DVS_W   = 16;
    localparam int GRADE_W = FRAC_W + 1;
    localparam int DEN_W   = 12;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 4;
    localparam int REG_CNT = 8;

    localparam logic [3:0] REG_CHG_CEN = 4'd3;
    localparam logic [3:0] REG_CHG_WID = 4'd4;

    localparam logic [GRADE_W-1:0] ONE_Q = GRADE_W'(1 << FRAC_W);
    localparam logic signed [DATA_W-1:0] DMAX = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] DMIN = -16'sh8000;

    typedef logic [DATA_W-1:0] q_t;

    typedef struct packed {
        q_t                  ref_val;
        q_t                  err_scale;
        q_t                  chg_scale;
        q_t                  out_gain;
        q_t [3:0]            e_cen;
        q_t [3:0]            e_wid;
        q_t [2:0]            c_cen;
        q_t [2:0]            c_wid;
        q_t [2:0][3:0]       wgt;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_GRADE,
        S_DIV_WAIT,
        S_STR_MUL,
        S_STR_ACC1,
        S_STR_ACC2,
        S_AVG,
        S_GAIN,
        S_CALC,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        JOB_SCALE,
        JOB_GRADE,
        JOB_AVG
    } job_t;

endpackage

// ===== hdl/fpd_in_if.sv =====
// Input channel of the fuzzy PD controller: one sample per item.
// Depends on fpd_pkg.
interface fpd_in_if;
    logic                         valid;
    logic                         ready;
    logic signed [fpd_pkg::DATA_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== hdl/fpd_out_if.sv =====
// Output channel of the fuzzy PD controller: drive and status flags.
// Depends on fpd_pkg.
interface fpd_out_if;
    logic                         valid;
    logic                         ready;
    logic signed [fpd_pkg::DATA_W-1:0] drive;
    logic                         no_rule_fired;
    logic                         saturated;

    modport source (output valid, output drive, output no_rule_fired, output saturated,
                    input ready);
    modport sink   (input valid, input drive, input no_rule_fired, input saturated,
                    output ready);
endinterface

// ===== hdl/fpd_regs.sv =====
// Configuration register file of the fuzzy PD controller.
// Depends on fpd_pkg; unpacks the eight registers into fields.
module fpd_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fpd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [fpd_pkg::CFG_W-1:0]   cfg_data,
    output fpd_pkg::cfg_t               cfg
);
    import fpd_pkg::*;

    logic [CFG_W-1:0] regs_reg [REG_CNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_CNT; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (cfg_we && !cfg_index[IDX_W-1])
        begin
            // change sets hold three fields only
            if (cfg_index == REG_CHG_CEN || cfg_index == REG_CHG_WID)
            begin
                regs_reg[cfg_index[IDX_W-2:0]] <= {16'd0, cfg_data[47:0]};
            end
            else
            begin
                regs_reg[cfg_index[IDX_W-2:0]] <= cfg_data;
            end
        end
    end

    assign cfg.ref_val   = regs_reg[0][15:0];
    assign cfg.err_scale = regs_reg[0][31:16];
    assign cfg.chg_scale = regs_reg[0][47:32];
    assign cfg.out_gain  = regs_reg[0][63:48];
    assign cfg.e_cen     = regs_reg[1];
    assign cfg.e_wid     = regs_reg[2];
    assign cfg.c_cen     = regs_reg[3][47:0];
    assign cfg.c_wid     = regs_reg[4][47:0];
    assign cfg.wgt[0]    = regs_reg[5];
    assign cfg.wgt[1]    = regs_reg[6];
    assign cfg.wgt[2]    = regs_reg[7];

endmodule

// ===== hdl/fpd_div.sv =====
// Shared restoring divider: one quotient bit per cycle on magnitudes.
// Depends on fpd_pkg; the divisor must be nonzero.
module fpd_div (
    input  logic              clk,
    input  logic              rst_n,
    input  fpd_pkg::div_req_t req,
    output fpd_pkg::div_rsp_t rsp
);
    import fpd_pkg::*;

    logic                 busy_reg;
    logic [4:0]           cnt_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [DVD_W-1:0]     q_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic                 done_reg;
    logic [DVS_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(DVD_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            q_reg   <= {q_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

// ===== hdl/fuzzy_pd_controller_core.sv =====
// Top level of the fuzzy PD controller: sequencer, shared multiplier,
// config registers (fpd_regs) and shared divider (fpd_div). Depends on fpd_pkg.
//
// One sample in, one result out. Each item runs through ten divisions on the
// shared 28-step divider (two scalings, seven grades, one weighted average)
// and twenty-five multiplies on the shared 18x18 multiplier (two for each of
// the twelve rules, one to apply the gain). The sequencer accepts, scales,
// grades, evaluates the rules, averages, applies the gain, saturates and hands
// off, in that order. A zero scale gain or a set with a full width below 2
// skips its division; no rule firing skips the average. The input is ready only
// while the sequencer is idle; a finished result waits in the output register
// while the next sample is accepted.
module fuzzy_pd_controller_core (
    input  logic                      clk,
    input  logic                      rst_n,
    fpd_in_if.sink                    in_ch,
    fpd_out_if.source                 out_ch,
    input  logic                      cfg_we,
    input  logic [fpd_pkg::IDX_W-1:0] cfg_index,
    input  logic [fpd_pkg::CFG_W-1:0] cfg_data
);
    import fpd_pkg::*;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    fpd_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fpd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    state_t                     state_reg, state_next;
    job_t                       job_reg, job_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic                       neg_reg, neg_next;
    logic signed [16:0]         err_reg, err_next;
    logic signed [17:0]         chg_reg, chg_next;
    logic signed [16:0]         prev_reg, prev_next;
    logic signed [DATA_W-1:0]   x1_reg, x1_next;
    logic signed [DATA_W-1:0]   x2_reg, x2_next;
    logic [GRADE_W-1:0]         m_reg [7];
    logic [GRADE_W-1:0]         m_next [7];
    logic signed [35:0]         prod_reg, prod_next;
    logic [DEN_W-1:0]           den_reg, den_next;
    logic signed [DVD_W-1:0]    num_reg, num_next;
    logic signed [16:0]         avg_reg, avg_next;
    logic signed [DATA_W-1:0]   res_drive_reg, res_drive_next;
    logic                       res_none_reg, res_none_next;
    logic                       res_sat_reg, res_sat_next;
    logic                       ovalid_reg, ovalid_next;
    logic signed [DATA_W-1:0]   odrive_reg, odrive_next;
    logic                       onone_reg, onone_next;
    logic                       osat_reg, osat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            prev_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            prev_reg   <= prev_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        idx_reg       <= idx_next;
        neg_reg       <= neg_next;
        err_reg       <= err_next;
        chg_reg       <= chg_next;
        x1_reg        <= x1_next;
        x2_reg        <= x2_next;
        m_reg         <= m_next;
        prod_reg      <= prod_next;
        den_reg       <= den_next;
        num_reg       <= num_next;
        avg_reg       <= avg_next;
        res_drive_reg <= res_drive_next;
        res_none_reg  <= res_none_next;
        res_sat_reg   <= res_sat_next;
        odrive_reg    <= odrive_next;
        onone_reg     <= onone_next;
        osat_reg      <= osat_next;
    end

    logic signed [17:0]       mul_a, mul_b;
    logic signed [35:0]       mul_p;
    logic signed [17:0]       sc_a;
    logic signed [DATA_W-1:0] sc_k;
    logic [17:0]              sc_mag;
    logic signed [DATA_W-1:0] sc_sat;
    logic signed [DATA_W-1:0] gx, gc, gw;
    logic signed [16:0]       gdiff;
    logic [15:0]              gd;
    logic [GRADE_W-1:0]       s_val;
    logic [DVD_W-1:0]         num_mag;
    logic [35:0]              p_mag;
    logic [27:0]              p_sh;
    logic [DVD_W-1:0]         q;
    logic                     out_free;

    assign q        = div_rsp.quotient;
    assign out_free = !ovalid_reg || out_ch.ready;

    // the one multiplier, operands picked by the sequencer
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        err_next       = err_reg;
        chg_next       = chg_reg;
        prev_next      = prev_reg;
        x1_next        = x1_reg;
        x2_next        = x2_reg;
        m_next         = m_reg;
        prod_next      = prod_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        avg_next       = avg_reg;
        res_drive_next = res_drive_reg;
        res_none_next  = res_none_reg;
        res_sat_next   = res_sat_reg;
        ovalid_next    = ovalid_reg;
        odrive_next    = odrive_reg;
        onone_next     = onone_reg;
        osat_next      = osat_reg;
        div_req        = '0;
        mul_a          = '0;
        mul_b          = '0;
        in_ch.ready    = 1'b0;

        sc_a   = (idx_reg == '0) ? 18'(err_reg) : chg_reg;
        sc_k   = (idx_reg == '0) ? $signed(cfg.err_scale) : $signed(cfg.chg_scale);
        sc_mag = sc_a[17] ? 18'(-sc_a) : 18'(sc_a);

        if (neg_reg)
        begin
            sc_sat = (q > DVD_W'(32768)) ? DMIN : DATA_W'(-q);
        end
        else
        begin
            sc_sat = (q > DVD_W'(32767)) ? DMAX : DATA_W'(q);
        end

        if (idx_reg < 4'd4)
        begin
            gx = x1_reg;
            gc = $signed(cfg.e_cen[idx_reg[1:0]]);
            gw = $signed(cfg.e_wid[idx_reg[1:0]]);
        end
        else
        begin
            gx = x2_reg;
            gc = $signed(cfg.c_cen[idx_reg[1:0]]);
            gw = $signed(cfg.c_wid[idx_reg[1:0]]);
        end
        gdiff = 17'(gx) - 17'(gc);
        gd    = gdiff[16] ? 16'(-gdiff) : 16'(gdiff);

        s_val   = prod_reg[16:8];
        num_mag = num_reg[DVD_W-1] ? DVD_W'(-num_reg) : DVD_W'(num_reg);
        p_mag   = prod_reg[35] ? 36'(-prod_reg) : 36'(prod_reg);
        p_sh    = p_mag[35:8];

        if (out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    err_next  = 17'(in_ch.sample) - 17'($signed(cfg.ref_val));
                    chg_next  = 18'(err_next) - 18'(prev_reg);
                    prev_next = err_next;
                    idx_next  = '0;
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (sc_k == '0)
                begin
                    // zero gain: saturate toward the sign of the dividend, or give zero if it is zero
                    if (sc_a == '0)
                    begin
                        sc_sat = '0;
                    end
                    else
                    begin
                        sc_sat = sc_a[17] ? DMIN : DMAX;
                    end
                    if (idx_reg == '0)
                    begin
                        x1_next  = sc_sat;
                        idx_next = 4'd1;
                    end
                    else
                    begin
                        x2_next    = sc_sat;
                        idx_next   = '0;
                        state_next = S_GRADE;
                    end
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'({sc_mag, 8'd0});
                    div_req.divisor  = sc_k[15] ? DVS_W'(-sc_k) : DVS_W'(sc_k);
                    neg_next         = sc_a[17] ^ sc_k[15];
                    job_next         = JOB_SCALE;
                    state_next       = S_DIV_WAIT;
                end
            end
            S_GRADE:
            begin
                if (gw < 16'sd2)
                begin
                    m_next[idx_reg[2:0]] = '0;
                    if (idx_reg == 4'd6)
                    begin
                        idx_next   = '0;
                        state_next = S_STR_MUL;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'({gd, 8'd0});
                    div_req.divisor  = DVS_W'(gw >>> 1);
                    job_next         = JOB_GRADE;
                    state_next       = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    case (job_reg)
                        JOB_SCALE:
                        begin
                            if (idx_reg == '0)
                            begin
                                x1_next    = sc_sat;
                                idx_next   = 4'd1;
                                state_next = S_SCALE;
                            end
                            else
                            begin
                                x2_next    = sc_sat;
                                idx_next   = '0;
                                state_next = S_GRADE;
                            end
                        end
                        JOB_GRADE:
                        begin
                            m_next[idx_reg[2:0]] = (q >= DVD_W'(ONE_Q)) ? '0
                                                   : GRADE_W'(ONE_Q - q[GRADE_W-1:0]);
                            if (idx_reg == 4'd6)
                            begin
                                idx_next   = '0;
                                den_next   = '0;
                                num_next   = '0;
                                state_next = S_STR_MUL;
                            end
                            else
                            begin
                                idx_next   = idx_reg + 4'd1;
                                state_next = S_GRADE;
                            end
                        end
                        default:
                        begin
                            avg_next   = neg_reg ? 17'(-q) : 17'(q);
                            state_next = S_GAIN;
                        end
                    endcase
                end
            end
            S_STR_MUL:
            begin
                if (idx_reg == '0)
                begin
                    den_next = '0;
                    num_next = '0;
                end
                mul_a      = 18'(m_reg[{1'b0, idx_reg[1:0]}]);
                mul_b      = 18'(m_reg[3'd4 + {1'b0, idx_reg[3:2]}]);
                prod_next  = mul_p;
                state_next = S_STR_ACC1;
            end
            S_STR_ACC1:
            begin
                den_next   = den_reg + DEN_W'(s_val);
                mul_a      = 18'(s_val);
                mul_b      = 18'($signed(cfg.wgt[idx_reg[3:2]][idx_reg[1:0]]));
                prod_next  = mul_p;
                state_next = S_STR_ACC2;
            end
            S_STR_ACC2:
            begin
                num_next = num_reg + DVD_W'(prod_reg);
                if (idx_reg == 4'd11)
                begin
                    state_next = S_AVG;
                end
                else
                begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = S_STR_MUL;
                end
            end
            S_AVG:
            begin
                if (den_reg == '0)
                begin
                    res_drive_next = '0;
                    res_none_next  = 1'b1;
                    res_sat_next   = 1'b0;
                    state_next     = S_FIN;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = num_mag;
                    div_req.divisor  = DVS_W'(den_reg);
                    neg_next         = num_reg[DVD_W-1];
                    job_next         = JOB_AVG;
                    state_next       = S_DIV_WAIT;
                end
            end
            S_GAIN:
            begin
                mul_a      = 18'($signed(cfg.out_gain));
                mul_b      = 18'(avg_reg);
                prod_next  = mul_p;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                res_none_next = 1'b0;
                if (prod_reg[35])
                begin
                    res_sat_next   = p_sh > 28'd32768;
                    res_drive_next = res_sat_next ? DMIN : DATA_W'(-p_sh);
                end
                else
                begin
                    res_sat_next   = p_sh > 28'd32767;
                    res_drive_next = res_sat_next ? DMAX : DATA_W'(p_sh);
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odrive_next = res_drive_reg;
                    onone_next  = res_none_reg;
                    osat_next   = res_sat_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_ch.valid         = ovalid_reg;
    assign out_ch.drive         = odrive_reg;
    assign out_ch.no_rule_fired = onone_reg;
    assign out_ch.saturated     = osat_reg;

endmodule
